/* hw/rtl/qtrm_pkg.sv */
// Shared types and constants for the quaternion to rotation matrix core.
package qtrm_pkg;

	// Component and output fraction widths.
	localparam int COMPONENT_BITS = 16;
	localparam int FRACTION_BITS  = 14;
	// Output entry width, Q1.FRACTION_BITS signed.
	localparam int OUT_BITS       = FRACTION_BITS + 2;
	// Norm and magnitude width: n reaches 2^(2*COMPONENT_BITS).
	localparam int NORM_BITS      = 2 * COMPONENT_BITS + 1;
	// Division steps: integer bit, fraction bits and the rounding bit.
	localparam int DIV_STEPS      = FRACTION_BITS + 2;
	// Number of matrix entries.
	localparam int ENTRIES        = 9;

	typedef struct packed {
		logic signed [COMPONENT_BITS-1:0] quat_w;
		logic signed [COMPONENT_BITS-1:0] quat_x;
		logic signed [COMPONENT_BITS-1:0] quat_y;
		logic signed [COMPONENT_BITS-1:0] quat_z;
	} quat_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] m00;
		logic signed [OUT_BITS-1:0] m01;
		logic signed [OUT_BITS-1:0] m02;
		logic signed [OUT_BITS-1:0] m10;
		logic signed [OUT_BITS-1:0] m11;
		logic signed [OUT_BITS-1:0] m12;
		logic signed [OUT_BITS-1:0] m20;
		logic signed [OUT_BITS-1:0] m21;
		logic signed [OUT_BITS-1:0] m22;
		logic                       zero_norm;
	} mat_t;

	// Classified item handed from the front to the back.
	typedef struct packed {
		logic                                zero;
		logic [NORM_BITS-1:0]                n;
		logic [ENTRIES-1:0]                  neg;
		logic [ENTRIES-1:0][NORM_BITS-1:0]   mag;
	} cls_t;

endpackage

/* hw/rtl/qtrm_front.sv */
// Front end: input capture, component products and numerator classification.
module qtrm_front import qtrm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_vld,
	input  quat_t quat,
	output logic  cls_vld,
	output cls_t  cls
);

	localparam int PW = 2 * COMPONENT_BITS;
	localparam int SW = 2 * COMPONENT_BITS + 3;

	logic  vld_s1, vld_s2;
	quat_t q_s1;
	logic signed [PW-1:0] ww_s2, xx_s2, yy_s2, zz_s2, xy_s2, wz_s2, xz_s2, wy_s2, yz_s2, wx_s2;
	logic signed [SW-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx, n;
	logic signed [SW-1:0] num [ENTRIES];
	cls_t cls_d;

	// Valid pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			cls_vld <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			cls_vld <= vld_s2;
		end
	end

	// Capture the accepted beat.
	always_ff @(posedge clk) begin
		if (in_vld) q_s1 <= quat;
	end

	// Ten component products, each registered.
	always_ff @(posedge clk) begin
		ww_s2 <= q_s1.quat_w * q_s1.quat_w;
		xx_s2 <= q_s1.quat_x * q_s1.quat_x;
		yy_s2 <= q_s1.quat_y * q_s1.quat_y;
		zz_s2 <= q_s1.quat_z * q_s1.quat_z;
		xy_s2 <= q_s1.quat_x * q_s1.quat_y;
		wz_s2 <= q_s1.quat_w * q_s1.quat_z;
		xz_s2 <= q_s1.quat_x * q_s1.quat_z;
		wy_s2 <= q_s1.quat_w * q_s1.quat_y;
		yz_s2 <= q_s1.quat_y * q_s1.quat_z;
		wx_s2 <= q_s1.quat_w * q_s1.quat_x;
	end

	// Norm and the nine numerators, split into sign and magnitude.
	always_comb begin
		ww = SW'(ww_s2); xx = SW'(xx_s2); yy = SW'(yy_s2); zz = SW'(zz_s2);
		xy = SW'(xy_s2); wz = SW'(wz_s2); xz = SW'(xz_s2); wy = SW'(wy_s2);
		yz = SW'(yz_s2); wx = SW'(wx_s2);
		n      = ww + xx + yy + zz;
		num[0] = n - ((yy + zz) <<< 1);
		num[1] = (xy - wz) <<< 1;
		num[2] = (xz + wy) <<< 1;
		num[3] = (xy + wz) <<< 1;
		num[4] = n - ((xx + zz) <<< 1);
		num[5] = (yz - wx) <<< 1;
		num[6] = (xz - wy) <<< 1;
		num[7] = (yz + wx) <<< 1;
		num[8] = n - ((xx + yy) <<< 1);
		cls_d.zero = (n == '0);
		cls_d.n    = n[NORM_BITS-1:0];
		for (int k = 0; k < ENTRIES; k++) begin
			cls_d.neg[k] = num[k][SW-1];
			cls_d.mag[k] = num[k][SW-1] ? NORM_BITS'(-num[k]) : num[k][NORM_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		cls <= cls_d;
	end

endmodule

/* hw/rtl/qtrm_fifo.sv */
// Two-entry queue of classified items between the front and the back.
module qtrm_fifo import qtrm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cls_t wdata,
	output logic full,
	input  logic rd,
	output logic nempty,
	output cls_t rdata
);

	cls_t       mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full   = (cnt_q == 2'd2);
	assign nempty = (cnt_q != 2'd0);
	assign rdata  = mem_q[rptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr) wptr_q <= ~wptr_q;
			if (rd) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wptr_q] <= wdata;
	end

endmodule

/* hw/rtl/qtrm_back.sv */
// Back end: pipelined restoring division of all nine entries by the norm, then rounding.
module qtrm_back import qtrm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_vld,
	input  cls_t cls,
	output logic done,
	output mat_t mat
);

	typedef struct packed {
		logic                              zero;
		logic [NORM_BITS-1:0]              n;
		logic [ENTRIES-1:0]                neg;
		logic [ENTRIES-1:0][NORM_BITS-1:0] rem;
		logic [ENTRIES-1:0][DIV_STEPS-1:0] q;
	} stp_t;

	localparam logic [OUT_BITS-1:0] ONE = OUT_BITS'(1) << FRACTION_BITS;

	stp_t             stg_s [DIV_STEPS+1];
	logic [DIV_STEPS:0] vld_s;
	logic [OUT_BITS-1:0] res [ENTRIES];

	// Stage zero takes the queue head directly.
	always_comb begin
		stg_s[0].zero = cls.zero;
		stg_s[0].n    = cls.n;
		stg_s[0].neg  = cls.neg;
		stg_s[0].rem  = cls.mag;
		stg_s[0].q    = '0;
	end
	assign vld_s[0] = in_vld;

	// One quotient bit per stage; the first stage compares without doubling.
	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		stp_t nxt;

		always_comb begin
			logic [NORM_BITS:0] dbl;
			logic               ge;
			nxt = stg_s[j];
			for (int k = 0; k < ENTRIES; k++) begin
				dbl = (j == 0) ? {1'b0, stg_s[j].rem[k]} : {stg_s[j].rem[k], 1'b0};
				ge  = (dbl >= {1'b0, stg_s[j].n});
				if (ge) dbl = dbl - {1'b0, stg_s[j].n};
				nxt.rem[k] = dbl[NORM_BITS-1:0];
				nxt.q[k]   = {stg_s[j].q[k][DIV_STEPS-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[j+1] <= 1'b0;
			else         vld_s[j+1] <= vld_s[j];
		end

		always_ff @(posedge clk) begin
			stg_s[j+1] <= nxt;
		end
	end

	// Round half away from zero on the magnitude, saturate, restore the sign; a zero norm gives the identity.
	always_comb begin
		logic [OUT_BITS-1:0] m;
		for (int k = 0; k < ENTRIES; k++) begin
			m = OUT_BITS'(stg_s[DIV_STEPS].q[k][DIV_STEPS-1:1])
				+ OUT_BITS'(stg_s[DIV_STEPS].q[k][0]);
			if (m > ONE) m = ONE;
			if (stg_s[DIV_STEPS].zero) res[k] = ((k % 4) == 0) ? ONE : '0;
			else if (stg_s[DIV_STEPS].neg[k]) res[k] = -m;
			else res[k] = m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= vld_s[DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		mat.m00       <= res[0];
		mat.m01       <= res[1];
		mat.m02       <= res[2];
		mat.m10       <= res[3];
		mat.m11       <= res[4];
		mat.m12       <= res[5];
		mat.m20       <= res[6];
		mat.m21       <= res[7];
		mat.m22       <= res[8];
		mat.zero_norm <= stg_s[DIV_STEPS].zero;
	end

	// The first diagonal entry, m00, never exceeds one in magnitude.
	a_diag_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (mat.m00 <= $signed(ONE)) && (mat.m00 >= -$signed(ONE)))
		else $error("diagonal entry out of range");

endmodule

/* hw/rtl/quaternion_to_rotation_matrix_core.sv */
// Top level of the quaternion to rotation matrix core.
// Takes one quaternion per clock when start is high and busy is low, and gives
// the nine Q1.14 entries of its rotation matrix with done high for one cycle.
// Each item passes through the front end, the queue and the pipelined restoring
// divider, one quotient bit per stage. Results cannot be held off; the back end
// drains the queue every cycle, so busy stays low and a new beat is taken in
// every cycle. An all-zero quaternion gives the identity matrix with
// zero_norm set.
module quaternion_to_rotation_matrix_core import qtrm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  quat_t quat,
	output logic  done,
	output mat_t  mat
);

	logic cls_vld, q_nempty;
	cls_t cls, q_head;

	qtrm_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.quat    (quat),
		.cls_vld (cls_vld),
		.cls     (cls)
	);

	qtrm_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cls_vld),
		.wdata  (cls),
		.full   (busy),
		.rd     (q_nempty),
		.nempty (q_nempty),
		.rdata  (q_head)
	);

	qtrm_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (q_nempty),
		.cls    (q_head),
		.done   (done),
		.mat    (mat)
	);

	// The back end drains every cycle, so the queue never fills.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("queue filled");

	// A zero quaternion yields the identity matrix.
	a_zero_ident: assert property (@(posedge clk) disable iff (!arst_n)
		done && mat.zero_norm |-> (mat.m00 == 16'sd16384) && (mat.m11 == 16'sd16384)
			&& (mat.m01 == 16'sd0) && (mat.m22 == 16'sd16384))
		else $error("zero quaternion not identity");

	// A rising done follows a valid item at the last divider stage.
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done) |-> $past(u_back.vld_s[DIV_STEPS]))
		else $error("result without item");

endmodule
